[src/lss_pkg.sv]
// Shared widths for the lifespan statistics block.
// No dependencies; the core, lss_div and lss_search refer to it by scoped names.
package lss_pkg;

	// Ages are unsigned Q6.8 days.
	localparam int AGE_W = 14;
	// Position of the whole-day part inside an age.
	localparam int FRAC_W = 8;
	// Width of the day index field.
	localparam int DAY_W = 6;
	// Width of the count fields of a result.
	localparam int OUT_CNT_W = 11;
	// Largest age value, the upper bound of the median search.
	localparam logic [AGE_W-1:0] AGE_MAX = '1;

endpackage

[src/lifespan_statistics_core.sv]
// Lifespan statistics: top level with the load path, the run sequencer and the output register.
// Depends on lss_pkg, lss_div, lss_hist and lss_search.
//
// Ages load one request per cycle into a dual-port age store, while the count, sum, maximum
// and per-day death counters update on the fly. The request marked final_item closes the set and
// the input stalls until the whole run is delivered: the serial divider forms the mean, then the
// median search makes 14 bisection passes over the store, and a second search runs for an even
// count. Day rows then leave one at a time, each after a registered read of the day counters. The age
// store needs no clearing pass; only written entries are ever read.
module lifespan_statistics_core #(
	parameter int MAX_ITEMS = 1024,
	parameter int DAY_ROWS  = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lss_pkg::AGE_W-1:0]     age,
	input  logic                          final_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lss_pkg::DAY_W-1:0]     day,
	output logic [lss_pkg::OUT_CNT_W-1:0] dead_count,
	output logic [lss_pkg::OUT_CNT_W-1:0] alive_count,
	output logic [lss_pkg::OUT_CNT_W-1:0] total_count,
	output logic [lss_pkg::AGE_W-1:0]     mean_age,
	output logic [lss_pkg::AGE_W-1:0]     median_age,
	output logic [lss_pkg::AGE_W-1:0]     max_age,
	output logic                          overflowed,
	output logic                          last_row
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int DW = $clog2(DAY_ROWS);
	localparam int SW = lss_pkg::AGE_W + CW;
	localparam int DAYP_W = lss_pkg::AGE_W - lss_pkg::FRAC_W;

	typedef enum logic [5:0] {
		ST_LOAD    = 6'b000001,
		ST_DIV     = 6'b000010,
		ST_MED_LO  = 6'b000100,
		ST_MED_HI  = 6'b001000,
		ST_EMIT_RD = 6'b010000,
		ST_EMIT_LD = 6'b100000
	} state_t;

	state_t                    state_q;
	logic                      go_q;
	logic [CW-1:0]             n_q;
	logic [SW-1:0]             sum_q;
	logic [lss_pkg::AGE_W-1:0] largest_q;
	logic                      drop_q;
	logic [CW-1:0]             k_q;
	logic [lss_pkg::AGE_W-1:0] mean_q;
	logic [lss_pkg::AGE_W-1:0] lowmid_q;
	logic [lss_pkg::AGE_W-1:0] median_q;
	logic [DW-1:0]             d_q;
	logic [CW-1:0]             cum_q;

	logic                          out_valid_q;
	logic [lss_pkg::DAY_W-1:0]     day_q;
	logic [lss_pkg::OUT_CNT_W-1:0] dead_q;
	logic [lss_pkg::OUT_CNT_W-1:0] alive_q;
	logic [lss_pkg::OUT_CNT_W-1:0] total_q;
	logic [lss_pkg::AGE_W-1:0]     mean_out_q;
	logic [lss_pkg::AGE_W-1:0]     median_out_q;
	logic [lss_pkg::AGE_W-1:0]     max_out_q;
	logic                          over_q;
	logic                          last_q;

	logic                      acc;
	logic                      has_room;
	logic [DAYP_W-1:0]         in_day;
	logic                      bin_en;
	logic                      hist_rd_en;
	logic [DW-1:0]             hist_addr;
	logic [CW-1:0]             hist_data;
	logic                      hist_clear;
	logic                      div_done;
	logic [lss_pkg::AGE_W-1:0] div_q;
	logic                      srch_start;
	logic                      srch_done;
	logic [lss_pkg::AGE_W-1:0] srch_res;
	logic [lss_pkg::AGE_W:0]   mid_pair;
	logic [DW-1:0]             maxday;
	logic                      slot_free;
	logic                      row_load;
	logic [CW-1:0]             cum_nx;
	logic                      is_last;

	// Input side of the load path.
	assign in_stall = (state_q != ST_LOAD);
	assign acc      = in_valid && !in_stall;
	assign has_room = n_q < CW'(MAX_ITEMS);
	assign in_day   = age[lss_pkg::AGE_W-1:lss_pkg::FRAC_W];
	assign bin_en   = acc && has_room && ({1'b0, in_day} < (DAYP_W + 1)'(DAY_ROWS));

	// Day counter read address: the binned day while loading, the row while emitting.
	assign hist_rd_en = bin_en || (state_q == ST_EMIT_RD);
	assign hist_addr  = (state_q == ST_EMIT_RD) ? d_q : DW'(in_day);

	// Last day row, clamped to the counter rows.
	assign maxday = (largest_q[lss_pkg::AGE_W-1:lss_pkg::FRAC_W] > DAYP_W'(DAY_ROWS - 1))
		? DW'(DAY_ROWS - 1) : DW'(largest_q[lss_pkg::AGE_W-1:lss_pkg::FRAC_W]);

	// Row formation into the output register.
	assign slot_free  = !out_valid_q || !out_stall;
	assign row_load   = (state_q == ST_EMIT_LD) && slot_free;
	assign cum_nx     = cum_q + hist_data;
	assign is_last    = (d_q == maxday);
	assign hist_clear = row_load && is_last;
	assign mid_pair   = {1'b0, lowmid_q} + {1'b0, srch_res};
	assign srch_start = go_q && ((state_q == ST_MED_LO) || (state_q == ST_MED_HI));

	lss_div #(
		.CW (CW),
		.SW (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (go_q && (state_q == ST_DIV)),
		.dividend (sum_q),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_q)
	);

	lss_hist #(
		.DAY_ROWS (DAY_ROWS),
		.CW       (CW),
		.DW       (DW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.bin_en  (bin_en),
		.rd_en   (hist_rd_en),
		.rd_addr (hist_addr),
		.clear   (hist_clear),
		.rd_data (hist_data)
	);

	lss_search #(
		.MAX_ITEMS (MAX_ITEMS),
		.CW        (CW),
		.AW        (AW)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (acc && has_room),
		.wr_addr (n_q[AW-1:0]),
		.wr_data (age),
		.start   (srch_start),
		.k       (k_q),
		.n       (n_q),
		.done    (srch_done),
		.result  (srch_res)
	);

	// Run sequencer and set accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			go_q      <= 1'b0;
			n_q       <= '0;
			sum_q     <= '0;
			largest_q <= '0;
			drop_q    <= 1'b0;
			k_q       <= '0;
			mean_q    <= '0;
			lowmid_q  <= '0;
			median_q  <= '0;
			d_q       <= '0;
			cum_q     <= '0;
		end else begin
			go_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (has_room) begin
							n_q   <= n_q + 1'b1;
							sum_q <= sum_q + SW'(age);
							if (age > largest_q) begin
								largest_q <= age;
							end
						end else begin
							drop_q <= 1'b1;
						end
						if (final_item) begin
							state_q <= ST_DIV;
							go_q    <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						mean_q <= div_q;
						go_q   <= 1'b1;
						if (n_q[0]) begin
							k_q     <= n_q >> 1;
							state_q <= ST_MED_HI;
						end else begin
							k_q     <= (n_q >> 1) - 1'b1;
							state_q <= ST_MED_LO;
						end
					end
				end
				ST_MED_LO: begin
					if (srch_done) begin
						lowmid_q <= srch_res;
						k_q      <= n_q >> 1;
						go_q     <= 1'b1;
						state_q  <= ST_MED_HI;
					end
				end
				ST_MED_HI: begin
					if (srch_done) begin
						median_q <= n_q[0] ? srch_res : mid_pair[lss_pkg::AGE_W:1];
						d_q      <= '0;
						cum_q    <= '0;
						state_q  <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (row_load) begin
						cum_q <= cum_nx;
						if (is_last) begin
							n_q       <= '0;
							sum_q     <= '0;
							largest_q <= '0;
							drop_q    <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							d_q     <= d_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (row_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (row_load) begin
			day_q        <= lss_pkg::DAY_W'(d_q);
			dead_q       <= lss_pkg::OUT_CNT_W'(hist_data);
			alive_q      <= lss_pkg::OUT_CNT_W'(n_q - cum_nx);
			total_q      <= lss_pkg::OUT_CNT_W'(n_q);
			mean_out_q   <= mean_q;
			median_out_q <= median_q;
			max_out_q    <= largest_q;
			over_q       <= drop_q;
			last_q       <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign day         = day_q;
	assign dead_count  = dead_q;
	assign alive_count = alive_q;
	assign total_count = total_q;
	assign mean_age    = mean_out_q;
	assign median_age  = median_out_q;
	assign max_age     = max_out_q;
	assign overflowed  = over_q;
	assign last_row    = last_q;

	// The stored count never passes the capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(MAX_ITEMS))
		else $error("stored count exceeds capacity");
	// A final request starts the run and closes the input.
	a_final_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		acc && final_item |=> in_stall && state_q == ST_DIV)
		else $error("final request did not start the run");
	// Rows never go past the last day.
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_LD |-> d_q <= maxday)
		else $error("row index passed the last day");
	// The cumulative deaths never exceed the set size.
	a_cum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_load |-> cum_nx <= n_q)
		else $error("cumulative deaths exceed the set size");

endmodule

[src/lss_div.sv]
// Restoring serial divider that produces the truncated mean, one quotient bit a cycle.
// Depends on lss_pkg for the age width.
module lss_div #(
	parameter int CW = 11,
	parameter int SW = 25
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [SW-1:0]              dividend,
	input  logic [CW-1:0]              divisor,
	output logic                       done,
	output logic [lss_pkg::AGE_W-1:0]  quotient
);

	localparam int IW = $clog2(SW + 1);

	logic [SW-1:0] dq_q;
	logic [CW-1:0] rem_q;
	logic [IW-1:0] iter_q;
	logic          busy_q;
	logic          done_q;
	logic [CW:0]   rem_sh;
	logic          fits;

	// One restoring step: shift in the next dividend bit and try the subtract.
	assign rem_sh = {rem_q, dq_q[SW-1]};
	assign fits   = rem_sh >= {1'b0, divisor};

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= IW'(SW);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == IW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient and remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[SW-2:0], fits};
			rem_q <= fits ? CW'(rem_sh - {1'b0, divisor}) : CW'(rem_sh);
		end
	end

	assign done     = done_q;
	assign quotient = dq_q[lss_pkg::AGE_W-1:0];

endmodule

[src/lss_hist.sv]
// Per-day death counters held in a small memory with read-modify-write and forwarding.
// Uses no package; valid bits clear the counters of a set all at once.
module lss_hist #(
	parameter int DAY_ROWS = 64,
	parameter int CW       = 11,
	parameter int DW       = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          bin_en,
	input  logic          rd_en,
	input  logic [DW-1:0] rd_addr,
	input  logic          clear,
	output logic [CW-1:0] rd_data
);

	logic [CW-1:0]       dd_mem [DAY_ROWS];
	logic [DAY_ROWS-1:0] dv_q;
	logic [CW-1:0]       rd_s1;
	logic                rdv_s1;
	logic                bin_s1;
	logic [DW-1:0]       day_s1;
	logic                bin_s2;
	logic [DW-1:0]       day_s2;
	logic [CW-1:0]       val_s2;
	logic [CW-1:0]       old_cnt;
	logic [CW-1:0]       new_cnt;

	// The previous write lands on the same edge as this read, so take it from stage two.
	assign old_cnt = (bin_s2 && day_s2 == day_s1) ? val_s2 : (rdv_s1 ? rd_s1 : '0);
	assign new_cnt = old_cnt + 1'b1;
	assign rd_data = rdv_s1 ? rd_s1 : '0;

	// Memory read and write ports.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1  <= dd_mem[rd_addr];
			rdv_s1 <= dv_q[rd_addr];
		end
		if (bin_s1) begin
			dd_mem[day_s1] <= new_cnt;
		end
		day_s1 <= rd_addr;
		day_s2 <= day_s1;
		val_s2 <= new_cnt;
	end

	// Pipeline control and entry valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_s1 <= 1'b0;
			bin_s2 <= 1'b0;
			dv_q   <= '0;
		end else begin
			bin_s1 <= bin_en;
			bin_s2 <= bin_s1;
			if (clear) begin
				dv_q <= '0;
			end else if (bin_s1) begin
				dv_q[day_s1] <= 1'b1;
			end
		end
	end

endmodule

[src/lss_search.sv]
// Age store and order-statistic search: a bisection over the age range, counting per pass.
// Depends on lss_pkg; one compare-and-count unit scans the store once per step.
module lss_search #(
	parameter int MAX_ITEMS = 1024,
	parameter int CW        = 11,
	parameter int AW        = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [lss_pkg::AGE_W-1:0] wr_data,
	input  logic                      start,
	input  logic [CW-1:0]             k,
	input  logic [CW-1:0]             n,
	output logic                      done,
	output logic [lss_pkg::AGE_W-1:0] result
);

	typedef enum logic [3:0] {
		SR_IDLE  = 4'b0001,
		SR_SETUP = 4'b0010,
		SR_SCAN  = 4'b0100,
		SR_DONE  = 4'b1000
	} sr_state_t;

	sr_state_t                 state_q;
	logic [lss_pkg::AGE_W-1:0] age_mem [MAX_ITEMS];
	logic [lss_pkg::AGE_W-1:0] rd_s1;
	logic                      rdv_s1;
	logic [lss_pkg::AGE_W-1:0] lo_q;
	logic [lss_pkg::AGE_W-1:0] hi_q;
	logic [lss_pkg::AGE_W-1:0] mid_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             cnt_q;
	logic                      rd_en;
	logic                      pass_end;
	logic [lss_pkg::AGE_W-1:0] lo_nx;
	logic [lss_pkg::AGE_W-1:0] hi_nx;

	assign rd_en    = (state_q == SR_SCAN) && (idx_q < n);
	assign pass_end = (state_q == SR_SCAN) && (idx_q == n) && !rdv_s1;

	// Narrow the interval by the count of the finished pass.
	always_comb begin
		lo_nx = lo_q;
		hi_nx = hi_q;
		if (cnt_q > k) begin
			hi_nx = mid_q;
		end else begin
			lo_nx = mid_q + 1'b1;
		end
	end

	// Age store with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			age_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1 <= age_mem[idx_q[AW-1:0]];
		end
	end

	// Search sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SR_IDLE;
			rdv_s1  <= 1'b0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			rdv_s1 <= rd_en;
			unique case (state_q)
				SR_IDLE: begin
					if (start) begin
						lo_q    <= '0;
						hi_q    <= lss_pkg::AGE_MAX;
						state_q <= SR_SETUP;
					end
				end
				SR_SETUP: begin
					mid_q   <= lo_q + ((hi_q - lo_q) >> 1);
					idx_q   <= '0;
					cnt_q   <= '0;
					state_q <= SR_SCAN;
				end
				SR_SCAN: begin
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rdv_s1 && rd_s1 <= mid_q) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (pass_end) begin
						lo_q    <= lo_nx;
						hi_q    <= hi_nx;
						state_q <= (lo_nx < hi_nx) ? SR_SETUP : SR_DONE;
					end
				end
				SR_DONE: begin
					state_q <= SR_IDLE;
				end
				default: begin
					state_q <= SR_IDLE;
				end
			endcase
		end
	end

	assign done   = (state_q == SR_DONE);
	assign result = lo_q;

	// A pass never reads beyond the stored entries.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= n || state_q != SR_SCAN)
		else $error("search index ran past the stored count");
	// The interval stays ordered during a search.
	a_interval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SR_SETUP |-> lo_q < hi_q)
		else $error("search step started on an empty interval");
	// The count of a pass never exceeds the entries read.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SR_SCAN |-> cnt_q <= idx_q)
		else $error("pass count exceeds entries read");

endmodule
